FILE: rtl/mct_pkg.sv
// shared constants and types of the min/max calibrated threshold detector
`default_nettype none
package mct_pkg;

  localparam int MAX_CH      = 4;
  localparam int SAMPLE_W    = 16;
  localparam int NODE_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int PCT_W       = 7;
  localparam int PROD_W      = SAMPLE_W + PCT_W;
  localparam int DIV_IN_W    = PROD_W - 2;
  localparam int RECIP_W     = 22;
  localparam int QUO_W       = DIV_IN_W + RECIP_W;
  localparam int RECIP_SHIFT = 26;

  localparam logic [SAMPLE_W-1:0] FULL16    = '1;
  localparam logic [PCT_W-1:0]    PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0]    PCT_RESET = 7'd50;
  // ceil(2^26 / 25), exact for (x >> 2) / 25 over the whole product range
  localparam logic [RECIP_W-1:0]  RECIP     = 22'd2684355;

  typedef struct packed {
    logic take;
    logic track;
    logic restart;
    logic adv2;
    logic adv_o;
    logic recomp;
    logic clear;
  } lane_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/minmax_calibrated_threshold.sv
// top level: mode control, per-channel lanes and result merge register
//
// One word is taken per clock while in_stall is low, and each gives at most
// one result word, which passes the stage 1 and stage 2 registers into the
// output register; calibrating words give none. The stages follow the recompute
// path of each channel lane: span times percent, then a reciprocal multiply
// for the divide by 100, then add and compare in the output register stage.
// Lanes run side by side, one per channel, and the output register merges
// their above bits and raw samples into one word.
// in_stall follows out_stall only when the three stages are all full. The
// percent register is written by cfg_write with cfg_data, clamped to 100.
`default_nettype none
module minmax_calibrated_threshold #(
  parameter int CHANNELS = mct_pkg::MAX_CH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mct_pkg::PCT_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          raw_mode,
  input  logic                          calibrating,
  input  logic                          recalc,
  input  logic [mct_pkg::NODE_W-1:0]    node_id,
  input  logic [mct_pkg::COUNT_W-1:0]   counter,
  input  logic [mct_pkg::SAMPLE_W-1:0]  sample_0,
  input  logic [mct_pkg::SAMPLE_W-1:0]  sample_1,
  input  logic [mct_pkg::SAMPLE_W-1:0]  sample_2,
  input  logic [mct_pkg::SAMPLE_W-1:0]  sample_3,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          is_raw,
  output logic [mct_pkg::NODE_W-1:0]    out_node_id,
  output logic [mct_pkg::COUNT_W-1:0]   out_counter,
  output logic [mct_pkg::MAX_CH-1:0]    above_bits,
  output logic [mct_pkg::SAMPLE_W-1:0]  raw_0,
  output logic [mct_pkg::SAMPLE_W-1:0]  raw_1,
  output logic [mct_pkg::SAMPLE_W-1:0]  raw_2,
  output logic [mct_pkg::SAMPLE_W-1:0]  raw_3
);
  import mct_pkg::*;

  logic [PCT_W-1:0]    pct;
  logic                calib_active;

  logic                v1;
  logic                raw1;
  logic                cal1;
  logic                rec1;
  logic                clr1;
  logic [NODE_W-1:0]   node1;
  logic [COUNT_W-1:0]  cnt1;

  logic                v2;
  logic                raw2;
  logic                cal2;
  logic                rec2;
  logic                clr2;
  logic [NODE_W-1:0]   node2;
  logic [COUNT_W-1:0]  cnt2;

  logic                take;
  logic                adv_o;
  logic                rdy2;
  logic                adv2;
  logic                ld_o;
  logic                is_cal;
  logic                restart;
  logic                recomp;

  lane_ctl_t           ctl;
  logic [SAMPLE_W-1:0] samp_in [MAX_CH];
  logic [SAMPLE_W-1:0] samp_w  [MAX_CH];
  logic [MAX_CH-1:0]   above_w;

  // handshake across the three stages
  assign adv_o    = !out_valid || !out_stall;
  assign rdy2     = !v2 || adv_o;
  assign adv2     = v1 && rdy2;
  assign ld_o     = v2 && adv_o;
  assign in_stall = v1 && !rdy2;
  assign take     = in_valid && !in_stall;

  assign is_cal  = !raw_mode && calibrating;
  assign restart = is_cal && !calib_active;
  assign recomp  = !raw_mode && !calibrating && (calib_active || recalc);

  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= PCT_RESET;
    end else if (cfg_write) begin
      pct <= (cfg_data > PCT_FULL) ? PCT_FULL : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_active <= 1'b0;
    end else if (take && !raw_mode) begin
      calib_active <= calibrating;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (take) begin
        v1 <= 1'b1;
      end else if (adv2) begin
        v1 <= 1'b0;
      end
      if (adv2) begin
        v2 <= 1'b1;
      end else if (ld_o) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      raw1  <= raw_mode;
      cal1  <= is_cal;
      rec1  <= recomp;
      clr1  <= restart;
      node1 <= node_id;
      cnt1  <= counter;
    end
    if (adv2) begin
      raw2  <= raw1;
      cal2  <= cal1;
      rec2  <= rec1;
      clr2  <= clr1;
      node2 <= node1;
      cnt2  <= cnt1;
    end
  end

  assign ctl.take    = take;
  assign ctl.track   = take && is_cal;
  assign ctl.restart = restart;
  assign ctl.adv2    = adv2;
  assign ctl.adv_o   = ld_o;
  assign ctl.recomp  = v2 && rec2;
  assign ctl.clear   = v2 && clr2;

  assign samp_in[0] = sample_0;
  assign samp_in[1] = sample_1;
  assign samp_in[2] = sample_2;
  assign samp_in[3] = sample_3;

  for (genvar c = 0; c < MAX_CH; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      mct_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .pct    (pct),
        .sample (samp_in[c]),
        .above  (above_w[c]),
        .samp_o (samp_w[c])
      );
    end else begin : g_off
      assign above_w[c] = 1'b0;
      assign samp_w[c]  = '0;
    end
  end

  // merge register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_o) begin
      out_valid <= v2 && !cal2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_o) begin
      is_raw      <= raw2;
      out_node_id <= node2;
      out_counter <= cnt2;
      above_bits  <= raw2 ? '0 : above_w;
      raw_0       <= raw2 ? samp_w[0] : '0;
      raw_1       <= raw2 ? samp_w[1] : '0;
      raw_2       <= raw2 ? samp_w[2] : '0;
      raw_3       <= raw2 ? samp_w[3] : '0;
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    pct <= PCT_FULL)
    else $error("percent register above full scale");

  a_raw_no_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_raw |-> above_bits == '0)
    else $error("raw word carries above bits");

  a_thr_no_raw: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_raw |-> (raw_0 == '0) && (raw_1 == '0) && (raw_2 == '0)
                             && (raw_3 == '0))
    else $error("threshold word carries raw samples");

  a_cal_start: assert property (@(posedge clk) disable iff (rst)
    take && is_cal |=> calib_active)
    else $error("calibration not active after calibrating word");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && out_valid)
    else $error("input stalled with a free stage");

endmodule
`default_nettype wire

FILE: rtl/mct_lane.sv
// one channel lane: min/max tracking, threshold recompute pipeline and compare
`default_nettype none
module mct_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  mct_pkg::lane_ctl_t            ctl,
  input  logic [mct_pkg::PCT_W-1:0]     pct,
  input  logic [mct_pkg::SAMPLE_W-1:0]  sample,
  output logic                          above,
  output logic [mct_pkg::SAMPLE_W-1:0]  samp_o
);
  import mct_pkg::*;

  logic [SAMPLE_W-1:0] chan_max;
  logic [SAMPLE_W-1:0] chan_min;
  logic [SAMPLE_W-1:0] chan_thresh;
  logic [SAMPLE_W-1:0] base_max;
  logic [SAMPLE_W-1:0] base_min;
  logic [SAMPLE_W-1:0] max_next;
  logic [SAMPLE_W-1:0] min_next;
  logic [SAMPLE_W-1:0] span;

  logic [SAMPLE_W-1:0] samp1;
  logic [SAMPLE_W-1:0] min1;
  logic                empty1;
  logic [PROD_W-1:0]   prod1;

  logic [SAMPLE_W-1:0] samp2;
  logic [SAMPLE_W-1:0] min2;
  logic                empty2;
  logic [SAMPLE_W-1:0] quot2;
  logic [QUO_W-1:0]    quot_full;

  logic [SAMPLE_W-1:0] thresh_calc;
  logic [SAMPLE_W-1:0] thresh_use;

  // range tracking at accept
  assign base_max = ctl.restart ? '0 : chan_max;
  assign base_min = ctl.restart ? FULL16 : chan_min;
  assign max_next = (sample > base_max) ? sample : base_max;
  assign min_next = (sample < base_min) ? sample : base_min;
  assign span     = chan_max - chan_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_max <= '0;
      chan_min <= FULL16;
    end else if (ctl.track) begin
      chan_max <= max_next;
      chan_min <= min_next;
    end
  end

  // stage 1: span times percent
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      samp1  <= sample;
      min1   <= chan_min;
      empty1 <= chan_max < chan_min;
      prod1  <= PROD_W'(span) * PROD_W'(pct);
    end
  end

  // stage 2: divide by 100 as (x >> 2) times reciprocal of 25
  assign quot_full = QUO_W'(prod1[PROD_W-1:2]) * QUO_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      samp2  <= samp1;
      min2   <= min1;
      empty2 <= empty1;
      quot2  <= quot_full[RECIP_SHIFT +: SAMPLE_W];
    end
  end

  // last stage: threshold select and compare
  assign thresh_calc = empty2 ? FULL16 : min2 + quot2;

  always_comb begin
    priority if (ctl.clear) begin
      thresh_use = FULL16;
    end else if (ctl.recomp) begin
      thresh_use = thresh_calc;
    end else begin
      thresh_use = chan_thresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_thresh <= FULL16;
    end else if (ctl.adv_o && (ctl.clear || ctl.recomp)) begin
      chan_thresh <= thresh_use;
    end
  end

  assign above  = samp2 > thresh_use;
  assign samp_o = samp2;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// self-checking testbench of the min/max calibrated threshold detector
`timescale 1ns / 1ps
module tb_top;
  import mct_pkg::*;

  localparam int LANES       = MAX_CH;
  localparam int RANDOM_WORDS = 1000;
  localparam int PHASE_WORDS  = 120;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 300000;

  typedef struct packed {
    logic                             raw_mode;
    logic                             calibrating;
    logic                             recalc;
    logic [NODE_W-1:0]                node_id;
    logic [COUNT_W-1:0]               counter;
    logic [MAX_CH-1:0][SAMPLE_W-1:0]  sample;
  } in_word_t;

  typedef struct packed {
    logic                             is_raw;
    logic [NODE_W-1:0]                node_id;
    logic [COUNT_W-1:0]               counter;
    logic [MAX_CH-1:0]                above;
    logic [MAX_CH-1:0][SAMPLE_W-1:0]  raw;
  } out_word_t;

  class threshold_model;
    logic [SAMPLE_W-1:0] lo [MAX_CH];
    logic [SAMPLE_W-1:0] hi [MAX_CH];
    logic [SAMPLE_W-1:0] thresh [MAX_CH];
    bit                  calib_active;
    int unsigned         percent;
    int                  failures;
    out_word_t           expected_words [$];

    function new();
      for (int c = 0; c < MAX_CH; c++) begin
        lo[c] = FULL16;
        hi[c] = '0;
        thresh[c] = FULL16;
      end
      calib_active = 0;
      percent = 32'(PCT_RESET);
      failures = 0;
    endfunction

    function void set_percent(int unsigned v);
      percent = (v > 32'(PCT_FULL)) ? 32'(PCT_FULL) : v;
    endfunction

    function logic [SAMPLE_W-1:0] recomputed(int ch);
      int unsigned span;
      int unsigned off;
      if (hi[ch] < lo[ch]) return FULL16;
      span = 32'(hi[ch]) - 32'(lo[ch]);
      off = (span * percent) / 32'(PCT_FULL);
      return SAMPLE_W'(32'(lo[ch]) + off);
    endfunction

    function logic [SAMPLE_W-1:0] thresh_for(int ch, bit forced);
      return (calib_active || forced) ? recomputed(ch) : thresh[ch];
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void take_input(in_word_t w);
      out_word_t r;
      r = '0;
      r.node_id = w.node_id;
      r.counter = w.counter;
      if (w.raw_mode) begin
        r.is_raw = 1'b1;
        for (int c = 0; c < LANES; c++) r.raw[c] = w.sample[c];
        expected_words.push_back(r);
        return;
      end
      if (w.calibrating) begin
        if (!calib_active) begin
          for (int c = 0; c < MAX_CH; c++) begin
            hi[c] = '0;
            lo[c] = FULL16;
            thresh[c] = FULL16;
          end
          calib_active = 1;
        end
        for (int c = 0; c < LANES; c++) begin
          if (w.sample[c] > hi[c]) hi[c] = w.sample[c];
          if (w.sample[c] < lo[c]) lo[c] = w.sample[c];
        end
        return;
      end
      if (calib_active || w.recalc) begin
        calib_active = 0;
        for (int c = 0; c < LANES; c++) thresh[c] = recomputed(c);
      end
      for (int c = 0; c < LANES; c++) r.above[c] = (w.sample[c] > thresh[c]);
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [SAMPLE_W-1:0] want,
                                logic [SAMPLE_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_output(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: node %0h counter %0h",
               got.node_id, got.counter);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("is_raw", SAMPLE_W'(want.is_raw), SAMPLE_W'(got.is_raw));
      compare_field("out_node_id", SAMPLE_W'(want.node_id), SAMPLE_W'(got.node_id));
      compare_field("out_counter", want.counter, got.counter);
      compare_field("above_bits", SAMPLE_W'(want.above), SAMPLE_W'(got.above));
      compare_field("raw_0", want.raw[0], got.raw[0]);
      compare_field("raw_1", want.raw[1], got.raw[1]);
      compare_field("raw_2", want.raw[2], got.raw[2]);
      compare_field("raw_3", want.raw[3], got.raw[3]);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [PCT_W-1:0]      cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  raw_mode = 1'b0;
  logic                  calibrating = 1'b0;
  logic                  recalc = 1'b0;
  logic [NODE_W-1:0]     node_id = '0;
  logic [COUNT_W-1:0]    counter = '0;
  logic [SAMPLE_W-1:0]   sample_0 = '0;
  logic [SAMPLE_W-1:0]   sample_1 = '0;
  logic [SAMPLE_W-1:0]   sample_2 = '0;
  logic [SAMPLE_W-1:0]   sample_3 = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  is_raw;
  logic [NODE_W-1:0]     out_node_id;
  logic [COUNT_W-1:0]    out_counter;
  logic [MAX_CH-1:0]     above_bits;
  logic [SAMPLE_W-1:0]   raw_0;
  logic [SAMPLE_W-1:0]   raw_1;
  logic [SAMPLE_W-1:0]   raw_2;
  logic [SAMPLE_W-1:0]   raw_3;

  threshold_model model;
  int burst_left = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int stall_mode = 0;
  int stall_run = 0;

  minmax_calibrated_threshold #(.CHANNELS(LANES)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .raw_mode(raw_mode),
    .calibrating(calibrating),
    .recalc(recalc),
    .node_id(node_id),
    .counter(counter),
    .sample_0(sample_0),
    .sample_1(sample_1),
    .sample_2(sample_2),
    .sample_3(sample_3),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_raw(is_raw),
    .out_node_id(out_node_id),
    .out_counter(out_counter),
    .above_bits(above_bits),
    .raw_0(raw_0),
    .raw_1(raw_1),
    .raw_2(raw_2),
    .raw_3(raw_3)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // result side: check accepted words, stall on a changing pattern
  always @(posedge clk) begin
    out_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got.is_raw = is_raw;
      got.node_id = out_node_id;
      got.counter = out_counter;
      got.above = above_bits;
      got.raw = {raw_3, raw_2, raw_1, raw_0};
      model.check_output(got);
    end
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_run = $urandom_range(10, 150);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 4) != 0);
      3: out_stall <= ~out_stall;
      default: out_stall <= ((stall_run % 7) < 3);
    endcase
  end

  function automatic in_word_t make_word(bit raw, bit cal, bit newt,
                                         logic [NODE_W-1:0] node,
                                         logic [COUNT_W-1:0] cnt,
                                         logic [SAMPLE_W-1:0] s0,
                                         logic [SAMPLE_W-1:0] s1,
                                         logic [SAMPLE_W-1:0] s2,
                                         logic [SAMPLE_W-1:0] s3);
    in_word_t w;
    w.raw_mode = raw;
    w.calibrating = cal;
    w.recalc = newt;
    w.node_id = node;
    w.counter = cnt;
    w.sample = {s3, s2, s1, s0};
    return w;
  endfunction

  function automatic in_word_t any_word(bit force_raw);
    return make_word(force_raw | 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), NODE_W'($urandom), COUNT_W'($urandom),
                     SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     SAMPLE_W'($urandom));
  endfunction

  function automatic logic [SAMPLE_W-1:0] sample_near(int unsigned mid,
                                                      int unsigned spread);
    longint v;
    v = longint'(mid) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return SAMPLE_W'(v);
  endfunction

  // samples around the threshold this word will be compared with
  function automatic logic [SAMPLE_W-1:0] probe_sample(int ch, bit newt);
    logic [SAMPLE_W-1:0] t;
    t = model.thresh_for(ch, newt);
    case ($urandom_range(0, 5))
      0: return t;
      1: return (t == FULL16) ? t : t + SAMPLE_W'(1);
      2: return (t == '0) ? t : t - SAMPLE_W'(1);
      3: return (model.lo[ch] <= model.hi[ch]) ?
                SAMPLE_W'($urandom_range(model.lo[ch], model.hi[ch])) :
                SAMPLE_W'($urandom);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    raw_mode <= w.raw_mode;
    calibrating <= w.calibrating;
    recalc <= w.recalc;
    node_id <= w.node_id;
    counter <= w.counter;
    sample_0 <= w.sample[0];
    sample_1 <= w.sample[1];
    sample_2 <= w.sample[2];
    sample_3 <= w.sample[3];
    do @(posedge clk); while (in_stall);
    model.take_input(w);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (model.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_percent(input int unsigned v);
    cfg_write <= 1'b1;
    cfg_data <= PCT_W'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    model.set_percent(v);
  endtask

  initial begin
    int unsigned mid [MAX_CH];
    int unsigned spread [MAX_CH];
    int phase;
    int phase_start;
    int random_start;
    int blk;
    bit newt;
    model = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before any calibration: thresholds are all ones
    send_word(make_word(0, 0, 0, 8'h01, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001));
    send_word(make_word(0, 0, 1, 8'h02, 16'h0002, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // raw extremes, raw over all other flags
    send_word(make_word(1, 0, 0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(1, 0, 0, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_word(make_word(1, 1, 1, 8'hA5, 16'h5A5A, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
    // calibration, first word sets min and max together
    send_word(make_word(0, 1, 0, 8'h10, 16'h0010, 16'd1000, 16'd0, 16'hFFFF, 16'd200));
    send_word(make_word(0, 1, 0, 8'h11, 16'h0011, 16'd3000, 16'd10, 16'd0, 16'd200));
    send_word(make_word(1, 1, 0, 8'h12, 16'h0012, 16'd9, 16'd9, 16'd9, 16'd9));
    send_word(make_word(0, 1, 1, 8'h13, 16'h0013, 16'd2000, 16'd5, 16'h8000, 16'd201));
    // first compare ends calibration
    send_word(make_word(0, 0, 0, 8'h20, 16'h0020, 16'd2000, 16'd6, 16'd32768, 16'd200));
    send_word(make_word(0, 0, 0, 8'h21, 16'h0021, 16'd2001, 16'd5, 16'd32767, 16'd201));
    send_word(make_word(0, 0, 0, 8'h22, 16'h0022, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_word(make_word(0, 0, 0, 8'h23, 16'h0023, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    drain();
    write_percent(127);
    send_word(make_word(0, 0, 1, 8'h30, 16'h0030, 16'd3000, 16'd10, 16'hFFFF, 16'd201));
    send_word(make_word(0, 0, 0, 8'h31, 16'h0031, 16'd3001, 16'd11, 16'hFFFF, 16'd202));
    drain();
    write_percent(0);
    send_word(make_word(0, 0, 1, 8'h40, 16'h0040, 16'd1000, 16'd0, 16'd0, 16'd200));
    send_word(make_word(0, 0, 0, 8'h41, 16'h0041, 16'd1001, 16'd1, 16'd1, 16'd201));
    drain();
    write_percent(50);

    phase = 0;
    phase_start = words_sent;
    random_start = words_sent;
    while (words_sent - random_start < RANDOM_WORDS) begin
      if (words_sent - phase_start >= PHASE_WORDS) begin
        drain();
        case (phase)
          0: write_percent(0);
          1: write_percent(100);
          2: write_percent(127);
          3: write_percent(1);
          4: write_percent(99);
          5: write_percent(101);
          default: write_percent($urandom_range(0, 127));
        endcase
        phase++;
        phase_start = words_sent;
      end
      case ($urandom_range(0, 9))
        0: begin
          blk = $urandom_range(1, 5);
          repeat (blk) send_word(any_word(0));
        end
        1: ;
        default: begin
          for (int c = 0; c < MAX_CH; c++) begin
            mid[c] = $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
              0: spread[c] = 0;
              1: spread[c] = 3;
              2: spread[c] = 300;
              default: spread[c] = 65535;
            endcase
          end
          blk = $urandom_range(1, 8);
          repeat (blk) begin
            if ($urandom_range(0, 7) == 0) send_word(any_word(1));
            send_word(make_word(0, 1, 1'($urandom_range(0, 1)), NODE_W'($urandom),
                                COUNT_W'($urandom), sample_near(mid[0], spread[0]),
                                sample_near(mid[1], spread[1]),
                                sample_near(mid[2], spread[2]),
                                sample_near(mid[3], spread[3])));
          end
        end
      endcase
      blk = $urandom_range(1, 12);
      repeat (blk) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(any_word(1));
        end else begin
          newt = ($urandom_range(0, 6) == 0);
          send_word(make_word(0, 0, newt, NODE_W'($urandom), COUNT_W'($urandom),
                              probe_sample(0, newt), probe_sample(1, newt),
                              probe_sample(2, newt), probe_sample(3, newt)));
        end
      end
    end

    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (model.failures == 0 && model.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mct_pkg.sv
rtl/mct_lane.sv
rtl/minmax_calibrated_threshold.sv
bench/tb_top.sv
